@@ hw/rtl/cstp_pkg.sv @@
// shared types, constants and helpers of the call stack time profiler
`default_nettype none

package cstp_pkg;

  // storage defaults
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned STACK_DEPTH   = 64;

  // fixed field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CALLS_W = 32;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned RIDX_W  = 6;
  localparam int unsigned IDXO_W  = 6;
  localparam int unsigned CNTO_W  = 7;

  // event codes
  localparam logic [ACT_W-1:0] ACT_START  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ENTER  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RETURN = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_RUN   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd5;

  // one procedure table entry
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CALLS_W-1:0] calls;
    logic [TIME_W-1:0]  sys;
    logic [TIME_W-1:0]  user;
  } entry_t;

  // table read address source
  typedef enum logic [1:0] {
    RSEL_CUR,
    RSEL_TGT,
    RSEL_RIDX,
    RSEL_SCAN
  } rsel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic              latch;
    logic              base_wr;
    logic              stop;
    logic              scan_clr;
    logic              scan_run;
    logic              tbl_rd;
    logic              stk_rd;
    logic              chg_wr;
    logic              push;
    logic              pop;
    logic              bump_wr;
    logic              capture;
    logic              sel_ridx;
    logic              zero;
    rsel_e             rsel;
    logic [STAT_W-1:0] status;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             running;
    logic             stack_empty;
    logic             stack_full;
    logic             table_full;
    logic             scan_fin;
    logic             found;
    logic             ridx_bad;
  } sts_t;

  // saturating add of two time values
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  // saturating call count increment
  function automatic logic [CALLS_W-1:0] sat_inc(input logic [CALLS_W-1:0] c);
    return (c == {CALLS_W{1'b1}}) ? c : c + CALLS_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cstp_ram.sv @@
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module cstp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/cstp_ctrl.sv @@
// event sequencer of the profiler: handshake, state machine and commands
`default_nettype none

module cstp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  output logic                 done_o,
  input  wire cstp_pkg::sts_t  sts_i,
  output cstp_pkg::ctl_t       ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CHECK,
    S_CHG_RD,
    S_CHG_WR,
    S_BUMP_RD,
    S_BUMP_WR,
    S_CUR_RD,
    S_CAPTURE
  } state_e;

  state_e                         state_q;
  logic [cstp_pkg::STAT_W-1:0]    code_q;
  logic                           sel_q;
  logic                           zero_q;
  logic                           done_q;
  logic                           accept;

  assign accept = start_i && (state_q == S_IDLE);

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= cstp_pkg::ST_OK;
      sel_q   <= 1'b0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            code_q  <= cstp_pkg::ST_OK;
            sel_q   <= 1'b0;
            zero_q  <= 1'b0;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (sts_i.action)
            cstp_pkg::ACT_ENTER: begin
              if (!sts_i.running) begin
                code_q  <= cstp_pkg::ST_NOT_RUN;
                state_q <= S_CUR_RD;
              end else begin
                state_q <= S_SCAN;
              end
            end
            cstp_pkg::ACT_RETURN: begin
              if (!sts_i.running) begin
                code_q  <= cstp_pkg::ST_NOT_RUN;
                state_q <= S_CUR_RD;
              end else if (sts_i.stack_empty) begin
                code_q  <= cstp_pkg::ST_UNDERFLOW;
                state_q <= S_CUR_RD;
              end else begin
                state_q <= S_CHG_RD;
              end
            end
            cstp_pkg::ACT_READ: begin
              sel_q <= 1'b1;
              if (sts_i.ridx_bad) begin
                code_q  <= cstp_pkg::ST_BAD_INDEX;
                zero_q  <= 1'b1;
                state_q <= S_CAPTURE;
              end else begin
                state_q <= S_CUR_RD;
              end
            end
            default: begin
              state_q <= S_CUR_RD;
            end
          endcase
        end
        S_SCAN: begin
          if (sts_i.scan_fin) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!sts_i.found && sts_i.table_full) begin
            code_q  <= cstp_pkg::ST_FULL;
            state_q <= S_CUR_RD;
          end else if (sts_i.stack_full) begin
            code_q  <= cstp_pkg::ST_OVERFLOW;
            state_q <= S_CUR_RD;
          end else begin
            state_q <= S_CHG_RD;
          end
        end
        S_CHG_RD: begin
          state_q <= S_CHG_WR;
        end
        S_CHG_WR: begin
          state_q <= (sts_i.action == cstp_pkg::ACT_ENTER) ? S_BUMP_RD : S_CUR_RD;
        end
        S_BUMP_RD: begin
          state_q <= S_BUMP_WR;
        end
        S_BUMP_WR: begin
          state_q <= S_CUR_RD;
        end
        S_CUR_RD: begin
          state_q <= S_CAPTURE;
        end
        S_CAPTURE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    ctl_o          = '0;
    ctl_o.rsel     = cstp_pkg::RSEL_CUR;
    ctl_o.status   = code_q;
    ctl_o.sel_ridx = sel_q;
    ctl_o.zero     = zero_q;
    ctl_o.latch    = accept;
    unique case (state_q)
      S_IDLE: begin
      end
      S_DISPATCH: begin
        ctl_o.base_wr  = (sts_i.action == cstp_pkg::ACT_START);
        ctl_o.stop     = (sts_i.action == cstp_pkg::ACT_STOP);
        ctl_o.scan_clr = (sts_i.action == cstp_pkg::ACT_ENTER) && sts_i.running;
      end
      S_SCAN: begin
        ctl_o.scan_run = 1'b1;
        ctl_o.rsel     = cstp_pkg::RSEL_SCAN;
      end
      S_CHECK: begin
      end
      S_CHG_RD: begin
        ctl_o.tbl_rd = 1'b1;
        ctl_o.stk_rd = 1'b1;
      end
      S_CHG_WR: begin
        ctl_o.chg_wr = 1'b1;
        ctl_o.push   = (sts_i.action == cstp_pkg::ACT_ENTER);
        ctl_o.pop    = (sts_i.action == cstp_pkg::ACT_RETURN);
      end
      S_BUMP_RD: begin
        ctl_o.tbl_rd = 1'b1;
        ctl_o.rsel   = cstp_pkg::RSEL_TGT;
      end
      S_BUMP_WR: begin
        ctl_o.bump_wr = 1'b1;
      end
      S_CUR_RD: begin
        ctl_o.tbl_rd = 1'b1;
        ctl_o.rsel   = sel_q ? cstp_pkg::RSEL_RIDX : cstp_pkg::RSEL_CUR;
      end
      S_CAPTURE: begin
        ctl_o.capture = 1'b1;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ hw/rtl/cstp_dpath.sv @@
// profiler datapath: event registers, procedure table, return stack, results
`default_nettype none

module cstp_dpath #(
  parameter int unsigned TABLE_ENTRIES = cstp_pkg::TABLE_ENTRIES,
  parameter int unsigned STACK_DEPTH   = cstp_pkg::STACK_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cstp_pkg::ctl_t                ctl_i,
  output cstp_pkg::sts_t                     sts_o,
  input  wire logic [cstp_pkg::ACT_W-1:0]    action_i,
  input  wire logic [cstp_pkg::KEY_W-1:0]    proc_key_i,
  input  wire logic [cstp_pkg::TIME_W-1:0]   sys_time_i,
  input  wire logic [cstp_pkg::TIME_W-1:0]   user_time_i,
  input  wire logic [cstp_pkg::RIDX_W-1:0]   read_index_i,
  output logic      [cstp_pkg::STAT_W-1:0]   status_o,
  output logic      [cstp_pkg::IDXO_W-1:0]   entry_index_o,
  output logic      [cstp_pkg::KEY_W-1:0]    entry_key_o,
  output logic      [cstp_pkg::CALLS_W-1:0]  call_count_o,
  output logic      [cstp_pkg::TIME_W-1:0]   sys_total_o,
  output logic      [cstp_pkg::TIME_W-1:0]   user_total_o,
  output logic      [cstp_pkg::CNTO_W-1:0]   entries_used_o,
  output logic      [cstp_pkg::CNTO_W-1:0]   depth_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SIdxW = $clog2(STACK_DEPTH);
  localparam int unsigned LvlW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TW    = cstp_pkg::TIME_W;

  // latched event
  logic [cstp_pkg::ACT_W-1:0]  act_q;
  logic [cstp_pkg::KEY_W-1:0]  key_q;
  logic [TW-1:0]               sys_q;
  logic [TW-1:0]               usr_q;
  logic [cstp_pkg::RIDX_W-1:0] ridx_q;

  // profiler state
  logic [CntW-1:0] used_q;
  logic [LvlW-1:0] level_q;
  logic [IdxW-1:0] cur_q;
  logic [TW-1:0]   prev_sys_q;
  logic [TW-1:0]   prev_usr_q;
  logic            running_q;

  // elapsed time since last charge
  logic [TW-1:0] ds_q;
  logic [TW-1:0] du_q;

  // key scan
  logic [CntW-1:0] scan_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            found_q;
  logic [IdxW-1:0] hit_q;
  logic            scan_end;
  logic            hit_now;
  logic            issue;
  logic [IdxW-1:0] tgt;

  // memories
  logic                      tbl_we;
  logic [IdxW-1:0]           tbl_waddr;
  cstp_pkg::entry_t          tbl_wdata;
  logic                      tbl_re;
  logic [IdxW-1:0]           tbl_raddr;
  cstp_pkg::entry_t          tbl_rdata;
  logic [IdxW-1:0]           stk_rdata;
  logic [LvlW-1:0]           lvl_dec;

  // result registers
  logic [cstp_pkg::STAT_W-1:0]  status_q;
  logic [cstp_pkg::IDXO_W-1:0]  index_q;
  logic [cstp_pkg::KEY_W-1:0]   okey_q;
  logic [cstp_pkg::CALLS_W-1:0] ocalls_q;
  logic [TW-1:0]                osys_q;
  logic [TW-1:0]                ousr_q;
  logic [cstp_pkg::CNTO_W-1:0]  oused_q;
  logic [cstp_pkg::CNTO_W-1:0]  odepth_q;

  // event beat capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      act_q  <= action_i;
      key_q  <= proc_key_i;
      sys_q  <= sys_time_i;
      usr_q  <= user_time_i;
      ridx_q <= read_index_i;
    end
  end

  // elapsed times, clamped at zero when a stamp goes backwards
  always_ff @(posedge clk_i) begin
    ds_q <= (sys_q >= prev_sys_q) ? sys_q - prev_sys_q : '0;
    du_q <= (usr_q >= prev_usr_q) ? usr_q - prev_usr_q : '0;
  end

  // scan control
  assign scan_end = (scan_q >= used_q);
  assign hit_now  = pend_q && (tbl_rdata.key == key_q);
  assign issue    = ctl_i.scan_run && !found_q && !hit_now && !scan_end;
  assign tgt      = found_q ? hit_q : used_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      found_q    <= 1'b0;
      hit_q      <= '0;
    end else if (ctl_i.scan_clr) begin
      scan_q  <= CntW'(1);
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (ctl_i.scan_run) begin
      pend_q <= issue;
      if (issue) begin
        pend_idx_q <= scan_q[IdxW-1:0];
        scan_q     <= scan_q + CntW'(1);
      end
      if (hit_now) begin
        found_q <= 1'b1;
        hit_q   <= pend_idx_q;
      end
    end
  end

  // profiler state updates
  assign lvl_dec = level_q - LvlW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      level_q    <= '0;
      cur_q      <= '0;
      prev_sys_q <= '0;
      prev_usr_q <= '0;
      running_q  <= 1'b0;
    end else begin
      if (ctl_i.base_wr) begin
        used_q     <= CntW'(1);
        level_q    <= '0;
        cur_q      <= '0;
        prev_sys_q <= sys_q;
        prev_usr_q <= usr_q;
        running_q  <= 1'b1;
      end
      if (ctl_i.stop) begin
        running_q <= 1'b0;
        cur_q     <= '0;
        level_q   <= '0;
      end
      if (ctl_i.chg_wr) begin
        prev_sys_q <= sys_q;
        prev_usr_q <= usr_q;
      end
      if (ctl_i.push) begin
        level_q <= level_q + LvlW'(1);
      end
      if (ctl_i.pop) begin
        level_q <= lvl_dec;
        cur_q   <= stk_rdata;
      end
      if (ctl_i.bump_wr) begin
        cur_q <= tgt;
        if (!found_q) begin
          used_q <= used_q + CntW'(1);
        end
      end
    end
  end

  // table read address
  assign tbl_re = issue || ctl_i.tbl_rd;

  always_comb begin
    unique case (ctl_i.rsel)
      cstp_pkg::RSEL_CUR:  tbl_raddr = cur_q;
      cstp_pkg::RSEL_TGT:  tbl_raddr = tgt;
      cstp_pkg::RSEL_RIDX: tbl_raddr = IdxW'(ridx_q);
      cstp_pkg::RSEL_SCAN: tbl_raddr = scan_q[IdxW-1:0];
    endcase
  end

  // table write: baseline, charge, or call count bump / insert
  assign tbl_we = ctl_i.base_wr || ctl_i.chg_wr || ctl_i.bump_wr;

  always_comb begin
    tbl_waddr = cur_q;
    tbl_wdata = tbl_rdata;
    if (ctl_i.base_wr) begin
      tbl_waddr = '0;
      tbl_wdata = '0;
    end else if (ctl_i.chg_wr) begin
      tbl_waddr      = cur_q;
      tbl_wdata.sys  = cstp_pkg::sat_add(tbl_rdata.sys, ds_q);
      tbl_wdata.user = cstp_pkg::sat_add(tbl_rdata.user, du_q);
    end else if (found_q) begin
      tbl_waddr       = tgt;
      tbl_wdata.calls = cstp_pkg::sat_inc(tbl_rdata.calls);
    end else begin
      tbl_waddr       = tgt;
      tbl_wdata.key   = key_q;
      tbl_wdata.calls = cstp_pkg::CALLS_W'(1);
      tbl_wdata.sys   = '0;
      tbl_wdata.user  = '0;
    end
  end

  cstp_ram #(
    .WIDTH ($bits(cstp_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // return stack: push at level, pop from level minus one
  cstp_ram #(
    .WIDTH (IdxW),
    .DEPTH (STACK_DEPTH)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (level_q[SIdxW-1:0]),
    .wdata_i (cur_q),
    .re_i    (ctl_i.stk_rd),
    .raddr_i (lvl_dec[SIdxW-1:0]),
    .rdata_o (stk_rdata)
  );

  // status toward the controller
  assign sts_o.action      = act_q;
  assign sts_o.running     = running_q;
  assign sts_o.stack_empty = (level_q == '0);
  assign sts_o.stack_full  = (level_q == LvlW'(STACK_DEPTH));
  assign sts_o.table_full  = (used_q == CntW'(TABLE_ENTRIES));
  assign sts_o.scan_fin    = found_q || (!pend_q && scan_end);
  assign sts_o.found       = found_q;
  assign sts_o.ridx_bad    = (32'(ridx_q) >= 32'(used_q));

  // result beat capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      status_q <= ctl_i.status;
      index_q  <= ctl_i.sel_ridx ? ridx_q : cstp_pkg::IDXO_W'(cur_q);
      okey_q   <= ctl_i.zero ? '0 : tbl_rdata.key;
      ocalls_q <= ctl_i.zero ? '0 : tbl_rdata.calls;
      osys_q   <= ctl_i.zero ? '0 : tbl_rdata.sys;
      ousr_q   <= ctl_i.zero ? '0 : tbl_rdata.user;
      oused_q  <= cstp_pkg::CNTO_W'(used_q);
      odepth_q <= cstp_pkg::CNTO_W'(level_q);
    end
  end

  assign status_o       = status_q;
  assign entry_index_o  = index_q;
  assign entry_key_o    = okey_q;
  assign call_count_o   = ocalls_q;
  assign sys_total_o    = osys_q;
  assign user_total_o   = ousr_q;
  assign entries_used_o = oused_q;
  assign depth_o        = odepth_q;

endmodule

`default_nettype wire

@@ hw/rtl/call_stack_time_profiler_core.sv @@
// Call stack time profiler. An event is taken when start_i is high while
// busy_o is low; each event gives exactly one result, shown for one cycle
// with done_o high, and the receiver cannot stall it. An enter event scans
// the procedure table for its key one entry per cycle through the table
// memory's single read port, so it takes longer as the table fills. busy_o
// drops in the done_o cycle, so the next event may be issued then. Table
// and stack memories need no clearing pass after reset: entries that have
// never been written are only reported before the first start event.
`default_nettype none

module call_stack_time_profiler_core #(
  parameter int unsigned TABLE_ENTRIES = cstp_pkg::TABLE_ENTRIES,
  parameter int unsigned STACK_DEPTH   = cstp_pkg::STACK_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [cstp_pkg::ACT_W-1:0]    action_i,
  input  wire logic [cstp_pkg::KEY_W-1:0]    proc_key_i,
  input  wire logic [cstp_pkg::TIME_W-1:0]   sys_time_i,
  input  wire logic [cstp_pkg::TIME_W-1:0]   user_time_i,
  input  wire logic [cstp_pkg::RIDX_W-1:0]   read_index_i,
  output logic                               done_o,
  output logic      [cstp_pkg::STAT_W-1:0]   status_o,
  output logic      [cstp_pkg::IDXO_W-1:0]   entry_index_o,
  output logic      [cstp_pkg::KEY_W-1:0]    entry_key_o,
  output logic      [cstp_pkg::CALLS_W-1:0]  call_count_o,
  output logic      [cstp_pkg::TIME_W-1:0]   sys_total_o,
  output logic      [cstp_pkg::TIME_W-1:0]   user_total_o,
  output logic      [cstp_pkg::CNTO_W-1:0]   entries_used_o,
  output logic      [cstp_pkg::CNTO_W-1:0]   depth_o
);

  cstp_pkg::ctl_t ctl;
  cstp_pkg::sts_t sts;

  // sequencer
  cstp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  // datapath with table and stack memories
  cstp_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .action_i       (action_i),
    .proc_key_i     (proc_key_i),
    .sys_time_i     (sys_time_i),
    .user_time_i    (user_time_i),
    .read_index_i   (read_index_i),
    .status_o       (status_o),
    .entry_index_o  (entry_index_o),
    .entry_key_o    (entry_key_o),
    .call_count_o   (call_count_o),
    .sys_total_o    (sys_total_o),
    .user_total_o   (user_total_o),
    .entries_used_o (entries_used_o),
    .depth_o        (depth_o)
  );

`ifndef SYNTH
  // an accepted beat keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted event did not raise busy");

  // a result strobe is never held high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // time is only charged while the profiler runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.chg_wr |-> sts.running)
    else $error("time charged while stopped");

  // push and pop never happen together, and only with a charge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.push || ctl.pop) |-> (ctl.chg_wr && !(ctl.push && ctl.pop)))
    else $error("stack update outside a charge cycle");
`endif

endmodule

`default_nettype wire
